// ===== rtl/sreh_pkg.sv =====
package sreh_pkg;

    // Rectangle edges, walked clockwise from the top-left corner
    localparam int NUM_EDGES = 4;

    typedef enum logic [1:0]
    {
        EDGE_TOP,
        EDGE_RIGHT,
        EDGE_BOTTOM,
        EDGE_LEFT
    } edge_id_t;

    // Top and bottom run along x, right and left along y
    function automatic logic edge_is_horiz(edge_id_t id);
        return (id == EDGE_TOP) || (id == EDGE_BOTTOM);
    endfunction

endpackage

// ===== rtl/segment_rect_edge_hit.sv =====
// Segment versus axis-aligned rectangle crossing test. Each input word carries a
// segment (start, end) and a box (left, top, width, height) in signed fixed point;
// the result word says whether the segment touches or crosses any of the four box
// edges, each edge checked with the exact parametric test (both line parameters in
// [0,1], endpoints on an edge count, parallel or zero-length cases do not). A
// segment lying wholly inside the box gives no hit. The block is a four-stage
// pipeline (operand prep, multiply, subtract, compare) that takes one word every
// cycle unless the pipeline is full and the output is stalled; each
// stage stalls on its own, so idle stages fill up while the output is held.
// Stage two multiplies operands of up to COORD_BITS+2 bits into signed products.
module segment_rect_edge_hit #(
    parameter int COORD_BITS = 20
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    input  logic signed [COORD_BITS-1:0] box_left,
    input  logic signed [COORD_BITS-1:0] box_top,
    input  logic        [COORD_BITS-2:0] box_width,
    input  logic        [COORD_BITS-2:0] box_height,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         hit
);

    localparam int W  = COORD_BITS;
    localparam int UW = W + 1;          // segment direction, far box corner
    localparam int DW = W + 2;          // start point minus edge origin
    localparam int MW = 2 * W + 3;      // products
    localparam int PW = 2 * W + 4;      // numerators and denominator
    localparam int NE = sreh_pkg::NUM_EDGES;

    // Per-stage advance: a stage moves when empty or when the next one moves
    logic adv1, adv2, adv3, adv4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    assign adv4     = !v4_reg || !out_stall;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_stall = !adv1;
    assign out_valid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // Stage 1: box corners, segment direction, edge origin offsets
    logic signed [UW-1:0] right_c, bottom_c;
    logic signed [UW-1:0] ux_next, uy_next, ux_reg, uy_reg;
    logic signed [DW-1:0] wx_next [NE];
    logic signed [DW-1:0] wy_next [NE];
    logic signed [W-1:0]  vc_next [NE];
    logic signed [DW-1:0] wx_reg  [NE];
    logic signed [DW-1:0] wy_reg  [NE];
    logic signed [W-1:0]  vc_reg  [NE];
    logic signed [UW-1:0] ox, oy;
    logic signed [W-1:0]  wd_s, ht_s;

    always_comb
    begin
        wd_s     = $signed({1'b0, box_width});
        ht_s     = $signed({1'b0, box_height});
        right_c  = UW'(box_left) + UW'(wd_s);
        bottom_c = UW'(box_top) + UW'(ht_s);
        ux_next  = UW'(end_x) - UW'(start_x);
        uy_next  = UW'(end_y) - UW'(start_y);
        for (int e = 0; e < NE; e++)
        begin
            case (sreh_pkg::edge_id_t'(e))
                sreh_pkg::EDGE_TOP:
                begin
                    ox = UW'(box_left);
                    oy = UW'(box_top);
                    vc_next[e] = wd_s;
                end
                sreh_pkg::EDGE_RIGHT:
                begin
                    ox = right_c;
                    oy = UW'(box_top);
                    vc_next[e] = ht_s;
                end
                sreh_pkg::EDGE_BOTTOM:
                begin
                    ox = right_c;
                    oy = bottom_c;
                    vc_next[e] = -wd_s;
                end
                default:
                begin
                    ox = UW'(box_left);
                    oy = bottom_c;
                    vc_next[e] = -ht_s;
                end
            endcase
            wx_next[e] = DW'(start_x) - DW'(ox);
            wy_next[e] = DW'(start_y) - DW'(oy);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            ux_reg <= ux_next;
            uy_reg <= uy_next;
            wx_reg <= wx_next;
            wy_reg <= wy_next;
            vc_reg <= vc_next;
        end
    end

    // Stage 2: four products per edge; edge direction has one nonzero axis
    logic signed [MW-1:0] pd_next [NE];
    logic signed [MW-1:0] pa_next [NE];
    logic signed [MW-1:0] pb_next [NE];
    logic signed [MW-1:0] pt_next [NE];
    logic signed [MW-1:0] pd_reg  [NE];
    logic signed [MW-1:0] pa_reg  [NE];
    logic signed [MW-1:0] pb_reg  [NE];
    logic signed [MW-1:0] pt_reg  [NE];
    logic signed [UW-1:0] dsel;
    logic signed [DW-1:0] tsel;

    always_comb
    begin
        for (int e = 0; e < NE; e++)
        begin
            if (sreh_pkg::edge_is_horiz(sreh_pkg::edge_id_t'(e)))
            begin
                dsel = uy_reg;
                tsel = wy_reg[e];
            end
            else
            begin
                dsel = ux_reg;
                tsel = wx_reg[e];
            end
            pd_next[e] = MW'(vc_reg[e]) * MW'(dsel);
            pt_next[e] = MW'(vc_reg[e]) * MW'(tsel);
            pa_next[e] = MW'(ux_reg) * MW'(wy_reg[e]);
            pb_next[e] = MW'(uy_reg) * MW'(wx_reg[e]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            pd_reg <= pd_next;
            pa_reg <= pa_next;
            pb_reg <= pb_next;
            pt_reg <= pt_next;
        end
    end

    // Stage 3: cross products; sign of den and nt depends on edge orientation
    logic signed [PW-1:0] den_next [NE];
    logic signed [PW-1:0] ns_next  [NE];
    logic signed [PW-1:0] nt_next  [NE];
    logic signed [PW-1:0] den_reg  [NE];
    logic signed [PW-1:0] ns_reg   [NE];
    logic signed [PW-1:0] nt_reg   [NE];

    always_comb
    begin
        for (int e = 0; e < NE; e++)
        begin
            ns_next[e] = PW'(pa_reg[e]) - PW'(pb_reg[e]);
            if (sreh_pkg::edge_is_horiz(sreh_pkg::edge_id_t'(e)))
            begin
                den_next[e] = -PW'(pd_reg[e]);
                nt_next[e]  = PW'(pt_reg[e]);
            end
            else
            begin
                den_next[e] = PW'(pd_reg[e]);
                nt_next[e]  = -PW'(pt_reg[e]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            den_reg <= den_next;
            ns_reg  <= ns_next;
            nt_reg  <= nt_next;
        end
    end

    // Stage 4: both parameters in [0,1], compare direction set by den's sign
    logic [NE-1:0] edge_hit;
    logic          hit_next, hit_reg;
    logic          den_neg, den_zero;

    always_comb
    begin
        for (int e = 0; e < NE; e++)
        begin
            den_neg  = den_reg[e][PW-1];
            den_zero = (den_reg[e] == '0);
            if (den_zero)
                edge_hit[e] = 1'b0;
            else if (!den_neg)
                edge_hit[e] = !ns_reg[e][PW-1] && (ns_reg[e] <= den_reg[e]) &&
                              !nt_reg[e][PW-1] && (nt_reg[e] <= den_reg[e]);
            else
                // negative den: numerators must lie in [den, 0]
                edge_hit[e] = (ns_reg[e][PW-1] || (ns_reg[e] == '0)) &&
                              (ns_reg[e] >= den_reg[e]) &&
                              (nt_reg[e][PW-1] || (nt_reg[e] == '0)) &&
                              (nt_reg[e] >= den_reg[e]);
        end
        hit_next = |edge_hit;
    end

    always_ff @(posedge clk)
    begin
        if (adv4)
            hit_reg <= hit_next;
    end

    assign hit = hit_reg;

    // Checks
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg))
        else $error("input stalled with an empty pipeline stage");

    a_free_output_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output is free");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
        |=> out_valid)
        else $error("accepted word did not reach the output in four cycles");

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;

    localparam int CB         = 20;
    localparam int RAND_WORDS = 2000;
    localparam int LIMIT      = 200000;

    // One stimulus word, plus an optional hand-typed expected hit
    typedef struct {
        logic signed [CB-1:0] sx;
        logic signed [CB-1:0] sy;
        logic signed [CB-1:0] ex;
        logic signed [CB-1:0] ey;
        logic signed [CB-1:0] left;
        logic signed [CB-1:0] top;
        logic        [CB-2:0] wid;
        logic        [CB-2:0] hgt;
        bit                   known;
        bit                   exp_hit;
    } seg_word_t;

    // Directed row: raw Q16.4 integers
    typedef struct {
        int sx;
        int sy;
        int ex;
        int ey;
        int left;
        int top;
        int wid;
        int hgt;
        bit known;
        bit exp_hit;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [CB-1:0] start_x;
    logic signed [CB-1:0] start_y;
    logic signed [CB-1:0] end_x;
    logic signed [CB-1:0] end_y;
    logic signed [CB-1:0] box_left;
    logic signed [CB-1:0] box_top;
    logic        [CB-2:0] box_width;
    logic        [CB-2:0] box_height;
    logic                 out_valid;
    logic                 out_stall;
    logic                 hit;

    seg_word_t stim_q[$];
    bit        hit_expect_q[$];
    dir_row_t  dir_table[0:15];
    int        taken_cnt  = 0;
    int        errors     = 0;
    int        cycles     = 0;
    bit        stim_done  = 0;

    segment_rect_edge_hit #(
        .COORD_BITS(CB)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .box_left   (box_left),
        .box_top    (box_top),
        .box_width  (box_width),
        .box_height (box_height),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hit        (hit)
    );

    // Exact parametric test of segment a-b against edge c-d
    function automatic bit seg_crosses(longint ax, longint ay, longint bx, longint by,
                                       longint cx, longint cy, longint dx, longint dy);
        longint ux;
        longint uy;
        longint vx;
        longint vy;
        longint wx;
        longint wy;
        longint den;
        longint ns;
        longint nt;
        ux  = bx - ax;
        uy  = by - ay;
        vx  = dx - cx;
        vy  = dy - cy;
        wx  = ax - cx;
        wy  = ay - cy;
        den = ux * vy - vx * uy;
        ns  = ux * wy - uy * wx;
        nt  = vx * wy - vy * wx;
        // parallel or zero-length: no crossing
        if (den == 0)
            return 1'b0;
        if (den < 0)
        begin
            den = -den;
            ns  = -ns;
            nt  = -nt;
        end
        return (ns >= 0) && (ns <= den) && (nt >= 0) && (nt <= den);
    endfunction

    // Hit flag for one word: any of the four box edges crossed
    function automatic bit predict_hit(seg_word_t w);
        longint sx;
        longint sy;
        longint ex;
        longint ey;
        longint l;
        longint t;
        longint r;
        longint b;
        sx = w.sx;
        sy = w.sy;
        ex = w.ex;
        ey = w.ey;
        l  = w.left;
        t  = w.top;
        // right and bottom one bit wider, never wrap
        r  = l + longint'(w.wid);
        b  = t + longint'(w.hgt);
        return seg_crosses(sx, sy, ex, ey, l, t, r, t) ||
               seg_crosses(sx, sy, ex, ey, r, t, r, b) ||
               seg_crosses(sx, sy, ex, ey, r, b, l, b) ||
               seg_crosses(sx, sy, ex, ey, l, b, l, t);
    endfunction

    function automatic int extreme_coord();
        case ($urandom_range(0, 4))
            0: return -524288;
            1: return 524287;
            2: return 0;
            3: return -1;
            default: return int'($urandom);
        endcase
    endfunction

    // Random word: some raw noise, most of it placed around a box
    function automatic seg_word_t rand_word();
        seg_word_t w;
        int        mode;
        int        span;
        int        lx;
        int        ty;
        int        wd;
        int        ht;
        int        x0;
        int        y0;
        int        x1;
        int        y1;
        mode      = $urandom_range(0, 99);
        w.known   = 1'b0;
        w.exp_hit = 1'b0;
        if (mode < 12)
        begin
            w.sx   = CB'($urandom);
            w.sy   = CB'($urandom);
            w.ex   = CB'($urandom);
            w.ey   = CB'($urandom);
            w.left = CB'($urandom);
            w.top  = CB'($urandom);
            w.wid  = (CB-1)'($urandom);
            w.hgt  = (CB-1)'($urandom);
        end
        else if (mode < 22)
        begin
            w.sx   = CB'(extreme_coord());
            w.sy   = CB'(extreme_coord());
            w.ex   = CB'(extreme_coord());
            w.ey   = CB'(extreme_coord());
            w.left = CB'(extreme_coord());
            w.top  = CB'(extreme_coord());
            w.wid  = (CB-1)'(extreme_coord());
            w.hgt  = (CB-1)'(extreme_coord());
        end
        else
        begin
            span = ($urandom_range(0, 3) == 0) ? 16 : 4000;
            lx   = int'($urandom_range(0, 1000000)) - 500000;
            ty   = int'($urandom_range(0, 1000000)) - 500000;
            wd   = $urandom_range(0, span);
            ht   = $urandom_range(0, span);
            x0   = lx - span + int'($urandom_range(0, wd + 2 * span));
            y0   = ty - span + int'($urandom_range(0, ht + 2 * span));
            x1   = lx - span + int'($urandom_range(0, wd + 2 * span));
            y1   = ty - span + int'($urandom_range(0, ht + 2 * span));
            case ($urandom_range(0, 9))
                // end point on a vertical edge
                0:
                begin
                    x1 = $urandom_range(0, 1) ? lx : lx + wd;
                    y1 = ty + int'($urandom_range(0, ht));
                end
                // end point on a horizontal edge
                1:
                begin
                    x1 = lx + int'($urandom_range(0, wd));
                    y1 = $urandom_range(0, 1) ? ty : ty + ht;
                end
                // zero-length segment
                2:
                begin
                    x1 = x0;
                    y1 = y0;
                end
                // collinear with the top edge
                3:
                begin
                    y0 = ty;
                    y1 = ty;
                end
                // flat box
                4:
                begin
                    if ($urandom_range(0, 1))
                        wd = 0;
                    else
                        ht = 0;
                end
                default:
                begin
                end
            endcase
            w.sx   = CB'(x0);
            w.sy   = CB'(y0);
            w.ex   = CB'(x1);
            w.ey   = CB'(y1);
            w.left = CB'(lx);
            w.top  = CB'(ty);
            w.wid  = (CB-1)'(wd);
            w.hgt  = (CB-1)'(ht);
        end
        return w;
    endfunction

    // Random idling, switched off over a quiet stretch
    function automatic bit idle_now(int taken);
        if (taken >= 1200 && taken < 1600)
            return 1'b0;
        return $urandom_range(0, 99) < 8;
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle limit
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= LIMIT)
            begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    // Input side: directed table, then random words
    initial
    begin : feed
        seg_word_t cur;
        seg_word_t w;
        int        total;
        in_valid   <= 1'b0;
        start_x    <= '0;
        start_y    <= '0;
        end_x      <= '0;
        end_y      <= '0;
        box_left   <= '0;
        box_top    <= '0;
        box_width  <= '0;
        box_height <= '0;
        dir_table = '{
            // straight through, inside, outside
            '{-1600, 800, 3200, 800, 0, 0, 1600, 1600, 1, 1},
            '{160, 160, 320, 320, 0, 0, 1600, 1600, 1, 0},
            '{3200, 3200, 4800, 4800, 0, 0, 1600, 1600, 1, 0},
            // end point touching the top edge
            '{800, -800, 800, 0, 0, 0, 1600, 1600, 1, 1},
            // collinear with the top edge
            '{-800, 0, 2400, 0, 0, 0, 1600, 1600, 0, 0},
            // zero-length segment on an edge
            '{800, 0, 800, 0, 0, 0, 1600, 1600, 1, 0},
            // point box: every edge zero length
            '{-100, 0, 100, 0, 0, 0, 0, 0, 1, 0},
            // zero-width box crossed
            '{-800, 800, 800, 800, 0, 0, 0, 1600, 0, 0},
            // full range diagonal from the box corner
            '{-524288, -524288, 524287, 524287, -524288, -524288, 524287, 524287, 0, 0},
            // all max, all min, zero-length
            '{524287, 524287, 524287, 524287, 524287, 524287, 524287, 524287, 1, 0},
            '{-524288, -524288, -524288, -524288, -524288, -524288, 0, 0, 1, 0},
            // right edge beyond coordinate range
            '{524000, -100, 524287, 100, 524200, -200, 524287, 400, 0, 0},
            // end point exactly on a corner
            '{-1600, -1600, 0, 0, 0, 0, 1600, 1600, 1, 1},
            // alternating bit patterns
            '{349525, -349526, -349526, 349525, 349525, -349526, 349525, 174762, 0, 0},
            '{-349526, 349525, 349525, -349526, -349526, 349525, 174762, 349525, 0, 0},
            // crossing the bottom edge
            '{800, 800, 800, 3200, 0, 0, 1600, 1600, 1, 1}
        };
        foreach (dir_table[i])
        begin
            w.sx      = CB'(dir_table[i].sx);
            w.sy      = CB'(dir_table[i].sy);
            w.ex      = CB'(dir_table[i].ex);
            w.ey      = CB'(dir_table[i].ey);
            w.left    = CB'(dir_table[i].left);
            w.top     = CB'(dir_table[i].top);
            w.wid     = (CB-1)'(dir_table[i].wid);
            w.hgt     = (CB-1)'(dir_table[i].hgt);
            w.known   = dir_table[i].known;
            w.exp_hit = dir_table[i].exp_hit;
            stim_q.push_back(w);
        end
        repeat (RAND_WORDS)
            stim_q.push_back(rand_word());
        total = stim_q.size();

        while (rst_n !== 1'b1)
            @(posedge clk);
        while (taken_cnt < total)
        begin
            @(posedge clk);
            if (in_valid && !in_stall)
            begin
                hit_expect_q.push_back(cur.known ? cur.exp_hit : predict_hit(cur));
                taken_cnt++;
            end
            // payload holds while stalled
            if (!in_valid || !in_stall)
            begin
                if (stim_q.size() != 0 && !idle_now(taken_cnt))
                begin
                    cur = stim_q.pop_front();
                    start_x    <= cur.sx;
                    start_y    <= cur.sy;
                    end_x      <= cur.ex;
                    end_y      <= cur.ey;
                    box_left   <= cur.left;
                    box_top    <= cur.top;
                    box_width  <= cur.wid;
                    box_height <= cur.hgt;
                    in_valid   <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
        stim_done = 1'b1;
    end

    // Output side: check each result word, random stalls, one long hold
    initial
    begin : drain
        bit want;
        int hold_left;
        bit pressed;
        out_stall <= 1'b0;
        hold_left = 0;
        pressed   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (hit_expect_q.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, actual hit=%0b",
                             $time, hit);
                    errors++;
                end
                else
                begin
                    want = hit_expect_q.pop_front();
                    if (hit !== want)
                    begin
                        $display("%0t: hit mismatch, expected %0b, actual %0b",
                                 $time, want, hit);
                        errors++;
                    end
                end
            end
            // long hold so the pipeline fills and stalls its input
            if (!pressed && taken_cnt >= 300)
            begin
                pressed   = 1'b1;
                hold_left = 200;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= idle_now(taken_cnt);
            end
        end
    end

    // Reset, then wait for the last result word
    initial
    begin
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        while (!stim_done || hit_expect_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
